FILE: rtl/qslerp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qslerp_pkg
// Shared constants for the quaternion slerp pipeline: field widths, fixed-point
// constants in Q.30 and the arc tangent table of the CORDIC cells.
// ----------------------------------------------------------------------------
package qslerp_pkg;

   localparam int COMPONENT_WIDTH_DEF = 16;
   localparam int CORDIC_STAGES_DEF   = 16;

   localparam int BLEND_W  = 17;
   localparam logic [BLEND_W-1:0] BLEND_ONE = 17'h10000;

   // square root of a Q.60 value: 31 root bits, 62-bit remainder
   localparam int ROOT_W     = 31;
   localparam int REM_W      = 62;
   localparam int SQRT_STEPS = 31;

   // cordic datapath widths
   localparam int XY_W  = 40;
   localparam int ZV_W  = 40;
   localparam int ZR_W  = 52;
   localparam int ANG_W = 34;

   // divider remainder width
   localparam int DREM_W = 32;

   localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
   localparam logic [63:0] PI_Q30       = 64'd3373259426;
   localparam logic [63:0] INV_GAIN_Q30 = 64'd652032874;

   localparam logic [31:0] ATAN_TAB [32] = '{
      32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
      32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
      32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
      32'd262143,    32'd131071,    32'd65535,     32'd32767,
      32'd16383,     32'd8191,      32'd4095,      32'd2047,
      32'd1023,      32'd511,       32'd255,       32'd127,
      32'd63,        32'd31,        32'd15,        32'd7,
      32'd3,         32'd1,         32'd0,         32'd0
   };

endpackage

FILE: rtl/qslerp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qslerp request and response channels
// Valid/ready channels carrying the slerp operands and the interpolated result.
// ----------------------------------------------------------------------------
interface qslerp_req_if #(
   parameter int W = qslerp_pkg::COMPONENT_WIDTH_DEF
) ();
   logic                              valid;
   logic                              ready;
   logic signed [W-1:0]               start_w;
   logic signed [W-1:0]               start_x;
   logic signed [W-1:0]               start_y;
   logic signed [W-1:0]               start_z;
   logic signed [W-1:0]               end_w;
   logic signed [W-1:0]               end_x;
   logic signed [W-1:0]               end_y;
   logic signed [W-1:0]               end_z;
   logic [qslerp_pkg::BLEND_W-1:0]    blend;

   modport source (output valid, start_w, start_x, start_y, start_z,
                   end_w, end_x, end_y, end_z, blend, input ready);
   modport sink   (input valid, start_w, start_x, start_y, start_z,
                   end_w, end_x, end_y, end_z, blend, output ready);
endinterface

interface qslerp_rsp_if #(
   parameter int W = qslerp_pkg::COMPONENT_WIDTH_DEF
) ();
   logic                valid;
   logic                ready;
   logic signed [W-1:0] out_w;
   logic signed [W-1:0] out_x;
   logic signed [W-1:0] out_y;
   logic signed [W-1:0] out_z;
   logic                degenerate;

   modport source (output valid, out_w, out_x, out_y, out_z, degenerate, input ready);
   modport sink   (input valid, out_w, out_x, out_y, out_z, degenerate, output ready);
endinterface

FILE: rtl/qslerp_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qslerp_sqrt_cell
// One root bit of a restoring integer square root, plus a side bus.
// ----------------------------------------------------------------------------
module qslerp_sqrt_cell #(
   parameter int K  = 0,
   parameter int SW = 1
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic [qslerp_pkg::REM_W-1:0]      rem_in,
   input  logic [qslerp_pkg::ROOT_W-1:0]     root_in,
   input  logic [SW-1:0]                     side_in,
   output logic [qslerp_pkg::REM_W-1:0]      rem_out,
   output logic [qslerp_pkg::ROOT_W-1:0]     root_out,
   output logic [SW-1:0]                     side_out
);
   localparam int RW = qslerp_pkg::REM_W;

   logic [RW-1:0]                  trial;
   logic                           take;
   logic [RW-1:0]                  rem_ff;
   logic [qslerp_pkg::ROOT_W-1:0]  root_ff;
   logic [SW-1:0]                  side_ff;

   always_comb begin
      trial = (RW'(root_in) << (K + 1)) + (RW'(1) << (2 * K));
      take  = (rem_in >= trial);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= take ? (rem_in - trial) : rem_in;
         root_ff <= take ? (root_in | (qslerp_pkg::ROOT_W'(1) << K)) : root_in;
         side_ff <= side_in;
      end
   end

   assign rem_out  = rem_ff;
   assign root_out = root_ff;
   assign side_out = side_ff;
endmodule

FILE: rtl/qslerp_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qslerp_cordic_cell
// One micro-rotation of a CORDIC, vectoring or rotation mode, plus a side bus.
// ----------------------------------------------------------------------------
module qslerp_cordic_cell #(
   parameter int IDX       = 0,
   parameter bit VECTORING = 1'b1,
   parameter int ZW        = qslerp_pkg::ZV_W,
   parameter int SW        = 1
) (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic signed [qslerp_pkg::XY_W-1:0]   x_in,
   input  logic signed [qslerp_pkg::XY_W-1:0]   y_in,
   input  logic signed [ZW-1:0]                 z_in,
   input  logic [SW-1:0]                        side_in,
   output logic signed [qslerp_pkg::XY_W-1:0]   x_out,
   output logic signed [qslerp_pkg::XY_W-1:0]   y_out,
   output logic signed [ZW-1:0]                 z_out,
   output logic [SW-1:0]                        side_out
);
   localparam int XW = qslerp_pkg::XY_W;
   localparam logic signed [ZW-1:0] STEP = ZW'(qslerp_pkg::ATAN_TAB[IDX]);

   logic signed [XW-1:0] xs;
   logic signed [XW-1:0] ys;
   logic                 up;
   logic signed [XW-1:0] x_ff;
   logic signed [XW-1:0] y_ff;
   logic signed [ZW-1:0] z_ff;
   logic [SW-1:0]        side_ff;

   always_comb begin
      xs = x_in >>> IDX;
      ys = y_in >>> IDX;
      up = VECTORING ? !y_in[XW-1] : z_in[ZW-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= up ? (x_in + ys) : (x_in - ys);
         y_ff    <= up ? (y_in - xs) : (y_in + xs);
         z_ff    <= up ? (z_in + STEP) : (z_in - STEP);
         side_ff <= side_in;
      end
   end

   assign x_out    = x_ff;
   assign y_out    = y_ff;
   assign z_out    = z_ff;
   assign side_out = side_ff;
endmodule

FILE: rtl/qslerp_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qslerp_div_cell
// One quotient bit of a restoring divider, plus a side bus.
// ----------------------------------------------------------------------------
module qslerp_div_cell #(
   parameter int NW = 49,
   parameter int SW = 1
) (
   input  logic                                clock,
   input  logic                                en,
   input  logic [qslerp_pkg::DREM_W-1:0]       rem_in,
   input  logic [NW-1:0]                       num_in,
   input  logic [qslerp_pkg::ROOT_W-1:0]       den_in,
   input  logic [SW-1:0]                       side_in,
   output logic [qslerp_pkg::DREM_W-1:0]       rem_out,
   output logic [NW-1:0]                       num_out,
   output logic [qslerp_pkg::ROOT_W-1:0]       den_out,
   output logic [SW-1:0]                       side_out
);
   localparam int DW = qslerp_pkg::DREM_W;

   logic [DW-1:0]                   rem2;
   logic                            take;
   logic [DW-1:0]                   rem_ff;
   logic [NW-1:0]                   num_ff;
   logic [qslerp_pkg::ROOT_W-1:0]   den_ff;
   logic [SW-1:0]                   side_ff;

   always_comb begin
      rem2 = {rem_in[DW-2:0], num_in[NW-1]};
      take = (rem2 >= DW'(den_in));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= take ? (rem2 - DW'(den_in)) : rem2;
         num_ff  <= {num_in[NW-2:0], take};
         den_ff  <= den_in;
         side_ff <= side_in;
      end
   end

   assign rem_out  = rem_ff;
   assign num_out  = num_ff;
   assign den_out  = den_ff;
   assign side_out = side_ff;
endmodule

FILE: rtl/quaternion_slerp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_slerp
// Fixed-point quaternion slerp: dot product, square root, vectoring CORDIC
// for the angle, two rotation CORDICs for the sines, and a restoring divider
// per component, all as rows of pipelined cells.
//
//   channel  dir  handshake     payload
//   req_ch   in   valid/ready   start_w..z, end_w..z, blend
//   rsp_ch   out  valid/ready   out_w..z, degenerate
//
// one transfer per cycle in and out while no result waits untaken; the
// depth of the pipeline is set by the sqrt, cordic and divider cell
// rows
// reset clears the valid bits only
// when a result waits untaken, the whole row holds and req_ch.ready drops
// ----------------------------------------------------------------------------
module quaternion_slerp #(
   parameter int COMPONENT_WIDTH = qslerp_pkg::COMPONENT_WIDTH_DEF,
   parameter int CORDIC_STAGES   = qslerp_pkg::CORDIC_STAGES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   qslerp_req_if.sink   req_ch,
   qslerp_rsp_if.source rsp_ch
);
   localparam int W     = COMPONENT_WIDTH;
   localparam int CS    = CORDIC_STAGES;
   localparam int BW    = qslerp_pkg::BLEND_W;
   localparam int XW    = qslerp_pkg::XY_W;
   localparam int ZV    = qslerp_pkg::ZV_W;
   localparam int ZR    = qslerp_pkg::ZR_W;
   localparam int AW    = qslerp_pkg::ANG_W;
   localparam int RTW   = qslerp_pkg::ROOT_W;
   localparam int RMW   = qslerp_pkg::REM_W;
   localparam int DRW   = qslerp_pkg::DREM_W;
   localparam int NSQ   = qslerp_pkg::SQRT_STEPS;
   localparam int FRAC2 = 2 * W - 4;
   localparam int DTW   = 2 * W + 2;
   localparam int EW    = (DTW > 34) ? DTW : 34;
   localparam int SH_DN = (FRAC2 >= 30) ? FRAC2 - 30 : 0;
   localparam int SH_UP = (FRAC2 < 30) ? 30 - FRAC2 : 0;
   localparam int PW    = AW + BW + 1;
   localparam int NPW   = W + 32;
   localparam int NW    = W + 33;
   localparam int LAT   = 5 + NSQ + 1 + CS + 2 + CS + 2 + NW;

   localparam int SQS   = 8 * W + BW + 32;
   localparam int VS    = 8 * W + BW + RTW + 1;
   localparam int R1S   = 8 * W + RTW;

   localparam logic signed [DTW-1:0] DOT_ONE = DTW'(1) <<< FRAC2;
   localparam logic signed [EW-1:0]  DN_BIAS = EW'((65'd1 << SH_DN) - 65'd1);
   localparam logic [RMW-1:0]        RAD_ONE = RMW'(1) << 60;
   localparam logic signed [ZV-1:0]  HALF_PI_V = ZV'(qslerp_pkg::HALF_PI_Q30);
   localparam logic signed [ZR-1:0]  HALF_PI_R = ZR'(qslerp_pkg::HALF_PI_Q30);
   localparam logic signed [ZR-1:0]  PI_R      = ZR'(qslerp_pkg::PI_Q30);
   localparam logic signed [XW-1:0]  INV_GAIN  = XW'(qslerp_pkg::INV_GAIN_Q30);
   localparam logic [NW-1:0]         POS_MAX   = NW'((64'd1 << (W - 1)) - 64'd1);
   localparam logic [NW-1:0]         NEG_MAG   = NW'(64'd1 << (W - 1));

   // flow control
   logic           en;
   logic           req_take;
   logic [LAT-1:0] vld_ff;
   logic           out_valid_ff;

   assign en           = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = en;
   assign req_take     = req_ch.valid && en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[LAT-2:0], req_take};
         out_valid_ff <= vld_ff[LAT-1];
      end
   end

   // input register
   logic [4*W-1:0] sq0_ff, eq0_ff;
   logic [BW-1:0]  t0_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sq0_ff <= {req_ch.start_z, req_ch.start_y, req_ch.start_x, req_ch.start_w};
         eq0_ff <= {req_ch.end_z, req_ch.end_y, req_ch.end_x, req_ch.end_w};
         t0_ff  <= (req_ch.blend > qslerp_pkg::BLEND_ONE) ? qslerp_pkg::BLEND_ONE
                                                          : req_ch.blend;
      end
   end

   // component products
   logic signed [2*W-1:0] prod_ff [4];
   logic [4*W-1:0]        sq1_ff, eq1_ff;
   logic [BW-1:0]         t1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            prod_ff[i] <= $signed(sq0_ff[i*W +: W]) * $signed(eq0_ff[i*W +: W]);
         end
         sq1_ff <= sq0_ff;
         eq1_ff <= eq0_ff;
         t1_ff  <= t0_ff;
      end
   end

   // dot product, clamp, rescale to Q.30
   logic signed [DTW-1:0] dsum, dclamp;
   logic signed [EW-1:0]  dot_e, c_full;
   logic signed [31:0]    c_in;
   logic signed [31:0]    c2_ff;
   logic [4*W-1:0]        sq2_ff, eq2_ff;
   logic [BW-1:0]         t2_ff;

   always_comb begin
      dsum = DTW'(prod_ff[0]) + DTW'(prod_ff[1]) + DTW'(prod_ff[2]) + DTW'(prod_ff[3]);
      if (dsum > DOT_ONE) begin
         dclamp = DOT_ONE;
      end else if (dsum < -DOT_ONE) begin
         dclamp = -DOT_ONE;
      end else begin
         dclamp = dsum;
      end
      dot_e  = EW'(dclamp);
      c_full = (FRAC2 >= 30) ? ((dot_e + (dot_e[EW-1] ? DN_BIAS : EW'(0))) >>> SH_DN)
                             : (dot_e <<< SH_UP);
      c_in   = c_full[31:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c2_ff  <= c_in;
         sq2_ff <= sq1_ff;
         eq2_ff <= eq1_ff;
         t2_ff  <= t1_ff;
      end
   end

   // c squared, then radicand 1 - c*c
   logic signed [63:0] cc_ff;
   logic signed [31:0] c3_ff, c4_ff;
   logic [4*W-1:0]     sq3_ff, eq3_ff, sq4_ff, eq4_ff;
   logic [BW-1:0]      t3_ff, t4_ff;
   logic [RMW-1:0]     rad_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         cc_ff  <= c2_ff * c2_ff;
         c3_ff  <= c2_ff;
         sq3_ff <= sq2_ff;
         eq3_ff <= eq2_ff;
         t3_ff  <= t2_ff;
         rad_ff <= RAD_ONE - cc_ff[RMW-1:0];
         c4_ff  <= c3_ff;
         sq4_ff <= sq3_ff;
         eq4_ff <= eq3_ff;
         t4_ff  <= t3_ff;
      end
   end

   // square root row
   logic [RMW-1:0] srem [NSQ+1];
   logic [RTW-1:0] sroot [NSQ+1];
   logic [SQS-1:0] sside [NSQ+1];

   assign srem[0]  = rad_ff;
   assign sroot[0] = '0;
   assign sside[0] = {sq4_ff, eq4_ff, t4_ff, c4_ff};

   for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
      qslerp_sqrt_cell #(.K(NSQ - 1 - j), .SW(SQS)) u_cell (
         .clock    (clock),
         .en       (en),
         .rem_in   (srem[j]),
         .root_in  (sroot[j]),
         .side_in  (sside[j]),
         .rem_out  (srem[j+1]),
         .root_out (sroot[j+1]),
         .side_out (sside[j+1])
      );
   end

   // vectoring setup
   logic [4*W-1:0]     sq5, eq5;
   logic [BW-1:0]      t5;
   logic signed [31:0] c5;
   logic [RTW-1:0]     s5;

   assign {sq5, eq5, t5, c5} = sside[NSQ];
   assign s5 = sroot[NSQ];

   logic signed [XW-1:0] vx [CS+1];
   logic signed [XW-1:0] vy [CS+1];
   logic signed [ZV-1:0] vz [CS+1];
   logic [VS-1:0]        vside [CS+1];
   logic signed [XW-1:0] vx0_ff, vy0_ff;
   logic signed [ZV-1:0] vz0_ff;
   logic [VS-1:0]        vside0_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (c5 < 0) begin
            vx0_ff <= XW'(s5);
            vy0_ff <= -XW'(c5);
            vz0_ff <= HALF_PI_V;
         end else begin
            vx0_ff <= XW'(c5);
            vy0_ff <= XW'(s5);
            vz0_ff <= '0;
         end
         vside0_ff <= {sq5, eq5, t5, s5, (s5 == '0)};
      end
   end

   assign vx[0]    = vx0_ff;
   assign vy[0]    = vy0_ff;
   assign vz[0]    = vz0_ff;
   assign vside[0] = vside0_ff;

   for (genvar j = 0; j < CS; j++) begin : g_vec
      qslerp_cordic_cell #(.IDX(j), .VECTORING(1'b1), .ZW(ZV), .SW(VS)) u_cell (
         .clock    (clock),
         .en       (en),
         .x_in     (vx[j]),
         .y_in     (vy[j]),
         .z_in     (vz[j]),
         .side_in  (vside[j]),
         .x_out    (vx[j+1]),
         .y_out    (vy[j+1]),
         .z_out    (vz[j+1]),
         .side_out (vside[j+1])
      );
   end

   // angle scaling by 1-t and t
   logic [4*W-1:0]     sq6, eq6;
   logic [BW-1:0]      t6;
   logic [RTW-1:0]     s6;
   logic               dg6;
   logic signed [AW-1:0] angle;
   logic signed [PW-1:0] p1_ff, p2_ff;
   logic [R1S-1:0]     r1side7_ff;
   logic               dg7_ff;

   assign {sq6, eq6, t6, s6, dg6} = vside[CS];
   assign angle = $signed(vz[CS][AW-1:0]);

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff      <= angle * $signed({1'b0, qslerp_pkg::BLEND_ONE - t6});
         p2_ff      <= angle * $signed({1'b0, t6});
         r1side7_ff <= {sq6, eq6, s6};
         dg7_ff     <= dg6;
      end
   end

   // fold arguments above pi/2
   logic signed [ZR-1:0] a1, a2;
   logic signed [ZR-1:0] z1_ff, z2_ff;
   logic [R1S-1:0]       r1side8_ff;
   logic                 dg8_ff;

   always_comb begin
      a1 = $signed({4'b0, {12{p1_ff[PW-1]}}, p1_ff[PW-1:16]});
      a2 = $signed({4'b0, {12{p2_ff[PW-1]}}, p2_ff[PW-1:16]});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         z1_ff      <= (a1 > HALF_PI_R) ? (PI_R - a1) : a1;
         z2_ff      <= (a2 > HALF_PI_R) ? (PI_R - a2) : a2;
         r1side8_ff <= r1side7_ff;
         dg8_ff     <= dg7_ff;
      end
   end

   // sine rows
   logic signed [XW-1:0] rx1 [CS+1];
   logic signed [XW-1:0] ry1 [CS+1];
   logic signed [ZR-1:0] rz1 [CS+1];
   logic [R1S-1:0]       rs1 [CS+1];
   logic signed [XW-1:0] rx2 [CS+1];
   logic signed [XW-1:0] ry2 [CS+1];
   logic signed [ZR-1:0] rz2 [CS+1];
   logic                 rs2 [CS+1];

   assign rx1[0] = INV_GAIN;
   assign ry1[0] = '0;
   assign rz1[0] = z1_ff;
   assign rs1[0] = r1side8_ff;
   assign rx2[0] = INV_GAIN;
   assign ry2[0] = '0;
   assign rz2[0] = z2_ff;
   assign rs2[0] = dg8_ff;

   for (genvar j = 0; j < CS; j++) begin : g_rot
      qslerp_cordic_cell #(.IDX(j), .VECTORING(1'b0), .ZW(ZR), .SW(R1S)) u_lane1 (
         .clock    (clock),
         .en       (en),
         .x_in     (rx1[j]),
         .y_in     (ry1[j]),
         .z_in     (rz1[j]),
         .side_in  (rs1[j]),
         .x_out    (rx1[j+1]),
         .y_out    (ry1[j+1]),
         .z_out    (rz1[j+1]),
         .side_out (rs1[j+1])
      );
      qslerp_cordic_cell #(.IDX(j), .VECTORING(1'b0), .ZW(ZR), .SW(1)) u_lane2 (
         .clock    (clock),
         .en       (en),
         .x_in     (rx2[j]),
         .y_in     (ry2[j]),
         .z_in     (rz2[j]),
         .side_in  (rs2[j]),
         .x_out    (rx2[j+1]),
         .y_out    (ry2[j+1]),
         .z_out    (rz2[j+1]),
         .side_out (rs2[j+1])
      );
   end

   // weighted sums
   logic [4*W-1:0]     sq9, eq9;
   logic [RTW-1:0]     s9;
   logic signed [31:0] sin1, sin2;

   assign {sq9, eq9, s9} = rs1[CS];
   assign sin1 = $signed(ry1[CS][31:0]);
   assign sin2 = $signed(ry2[CS][31:0]);

   logic signed [NPW-1:0] na_ff [4];
   logic signed [NPW-1:0] nb_ff [4];
   logic [4*W-1:0]        sq10_ff;
   logic [RTW-1:0]        s10_ff;
   logic                  dg10_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            na_ff[i] <= $signed(sq9[i*W +: W]) * sin1;
            nb_ff[i] <= $signed(eq9[i*W +: W]) * sin2;
         end
         sq10_ff <= sq9;
         s10_ff  <= s9;
         dg10_ff <= rs2[CS];
      end
   end

   logic signed [NW-1:0] nsum [4];
   logic [NW-1:0]        nmag [4];
   logic [NW-1:0]        num11_ff [4];
   logic                 neg11_ff [4];
   logic [4*W-1:0]       sq11_ff;
   logic [RTW-1:0]       s11_ff;
   logic                 dg11_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         nsum[i] = NW'(na_ff[i]) + NW'(nb_ff[i]);
         nmag[i] = nsum[i][NW-1] ? NW'(-nsum[i]) : NW'(nsum[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            num11_ff[i] <= nmag[i] + NW'(s10_ff >> 1);
            neg11_ff[i] <= nsum[i][NW-1];
         end
         sq11_ff <= sq10_ff;
         s11_ff  <= s10_ff;
         dg11_ff <= dg10_ff;
      end
   end

   // divider rows, one per component
   logic [4*W-1:0] dq_sq;
   logic [3:0]     dq_neg;
   logic [NW-1:0]  dq_num [4];
   logic           dq_dg;

   for (genvar k = 0; k < 4; k++) begin : g_lane
      localparam int LS = (k == 0) ? W + 2 : W + 1;

      logic [DRW-1:0] drem [NW+1];
      logic [NW-1:0]  dnum [NW+1];
      logic [RTW-1:0] dden [NW+1];
      logic [LS-1:0]  dside [NW+1];

      assign drem[0] = '0;
      assign dnum[0] = num11_ff[k];
      assign dden[0] = s11_ff;

      if (k == 0) begin : g_head
         assign dside[0] = {dg11_ff, neg11_ff[k], sq11_ff[k*W +: W]};
         assign dq_dg    = dside[NW][W+1];
      end else begin : g_rest
         assign dside[0] = {neg11_ff[k], sq11_ff[k*W +: W]};
      end

      for (genvar j = 0; j < NW; j++) begin : g_div
         qslerp_div_cell #(.NW(NW), .SW(LS)) u_cell (
            .clock    (clock),
            .en       (en),
            .rem_in   (drem[j]),
            .num_in   (dnum[j]),
            .den_in   (dden[j]),
            .side_in  (dside[j]),
            .rem_out  (drem[j+1]),
            .num_out  (dnum[j+1]),
            .den_out  (dden[j+1]),
            .side_out (dside[j+1])
         );
      end

      assign dq_num[k]          = dnum[NW];
      assign dq_neg[k]          = dside[NW][W];
      assign dq_sq[k*W +: W]    = dside[NW][W-1:0];
   end

   // restore sign, saturate, or pass the start on degenerate; output register
   logic [W-1:0]   res [4];
   logic [NW-1:0]  qneg [4];
   logic [W-1:0]   out_ff [4];
   logic           dg_out_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         qneg[i] = ~dq_num[i] + NW'(1);
         if (dq_dg) begin
            res[i] = dq_sq[i*W +: W];
         end else if (!dq_neg[i]) begin
            res[i] = (dq_num[i] > POS_MAX) ? POS_MAX[W-1:0] : dq_num[i][W-1:0];
         end else begin
            res[i] = (dq_num[i] > NEG_MAG) ? NEG_MAG[W-1:0] : qneg[i][W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            out_ff[i] <= res[i];
         end
         dg_out_ff <= dq_dg;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.out_w      = $signed(out_ff[0]);
   assign rsp_ch.out_x      = $signed(out_ff[1]);
   assign rsp_ch.out_y      = $signed(out_ff[2]);
   assign rsp_ch.out_z      = $signed(out_ff[3]);
   assign rsp_ch.degenerate = dg_out_ff;
endmodule

FILE: rtl/qslerp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qslerp_checker
// Port-level checks on the slerp block: reset, flow control and result hold.
// ----------------------------------------------------------------------------
module qslerp_checker #(
   parameter int W = qslerp_pkg::COMPONENT_WIDTH_DEF
) (
   input logic         clock,
   input logic         reset,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input logic [W-1:0] rsp_out_w,
   input logic [W-1:0] rsp_out_z,
   input logic         rsp_degenerate
);

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // input side stalls only behind an untaken result
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request stalled without a waiting result");

   // a free output means the input is open
   a_ready_open: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request stalled although result side is ready");

   // an untaken result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_w)
         && $stable(rsp_out_z) && $stable(rsp_degenerate)))
      else $error("waiting result changed");

endmodule

bind quaternion_slerp qslerp_checker #(.W(COMPONENT_WIDTH)) u_qslerp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_out_w      (rsp_ch.out_w),
   .rsp_out_z      (rsp_ch.out_z),
   .rsp_degenerate (rsp_ch.degenerate)
);

FILE: tb/tb_quaternion_slerp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_slerp
// Drives slerp requests through the valid/ready request channel and checks
// every response, field by field, against a bit-exact fixed-point slerp
// predictor. Directed corners come first, then random unit quaternion pairs
// mixed with full-range noise, under varying idle patterns on both sides.
// ----------------------------------------------------------------------------
module tb_quaternion_slerp;

   localparam int W = qslerp_pkg::COMPONENT_WIDTH_DEF;
   localparam int N_STAGES = qslerp_pkg::CORDIC_STAGES_DEF;
   localparam int N_RANDOM = 530;

   typedef struct {
      logic signed [W-1:0]            s[4];
      logic signed [W-1:0]            e[4];
      logic [qslerp_pkg::BLEND_W-1:0] blend;
      bit                             drain;
   } slerp_req_type;

   typedef struct {
      logic signed [W-1:0] q[4];
      logic                degenerate;
   } slerp_rsp_type;

   logic clock;
   logic reset;

   qslerp_req_if #(.W(W)) req_ch ();
   qslerp_rsp_if #(.W(W)) rsp_ch ();

   quaternion_slerp dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   slerp_req_type pending_q[$];
   slerp_rsp_type expected_q[$];
   int            n_accepted;
   int            n_errors;
   bit            req_took;
   int            tx_idle;
   int            rx_idle;
   int            hold_cnt;
   bit            hold_done;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic longint angle_of(longint c, longint s);
      longint x, y, z, xs, ys;
      if (c < 0) begin
         x = s; y = -c; z = longint'(qslerp_pkg::HALF_PI_Q30);
      end else begin
         x = c; y = s; z = 0;
      end
      for (int i = 0; i < N_STAGES && i < 32; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys; y -= xs; z += longint'(qslerp_pkg::ATAN_TAB[i]);
         end else begin
            x -= ys; y += xs; z -= longint'(qslerp_pkg::ATAN_TAB[i]);
         end
      end
      return z;
   endfunction

   function automatic longint sine_of(longint a);
      longint x, y, z, xs, ys;
      x = longint'(qslerp_pkg::INV_GAIN_Q30);
      y = 0;
      if (a > longint'(qslerp_pkg::HALF_PI_Q30))
         a = longint'(qslerp_pkg::PI_Q30) - a;
      z = a;
      for (int i = 0; i < N_STAGES && i < 32; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= longint'(qslerp_pkg::ATAN_TAB[i]);
         end else begin
            x += ys; y -= xs; z += longint'(qslerp_pkg::ATAN_TAB[i]);
         end
      end
      return y;
   endfunction

   function automatic slerp_rsp_type predict_slerp(slerp_req_type it);
      slerp_rsp_type r;
      longint dot, c, s, angle, s1, s2, n, mag, q;
      longint one;
      longint unsigned t, rem, root, b;
      one = longint'(1) << (2 * (W - 2));
      t = it.blend;
      if (t > qslerp_pkg::BLEND_ONE)
         t = qslerp_pkg::BLEND_ONE;
      dot = 0;
      for (int i = 0; i < 4; i++)
         dot += longint'(it.s[i]) * longint'(it.e[i]);
      if (dot > one) dot = one;
      if (dot < -one) dot = -one;
      c = dot * (longint'(1) << (30 - 2 * (W - 2)));
      rem = longint'((longint'(1) << 60) - c * c);
      root = 0;
      b = longint'(1) << 62;
      while (b > rem)
         b >>= 2;
      while (b != 0) begin
         if (rem >= root + b) begin
            rem -= root + b;
            root = (root >> 1) + b;
         end else begin
            root >>= 1;
         end
         b >>= 2;
      end
      s = longint'(root);
      if (s == 0) begin
         r.degenerate = 1'b1;
         for (int i = 0; i < 4; i++)
            r.q[i] = it.s[i];
      end else begin
         r.degenerate = 1'b0;
         angle = angle_of(c, s);
         s1 = sine_of(longint'((longint'(unsigned'(angle)) *
                               (qslerp_pkg::BLEND_ONE - t)) >> 16));
         s2 = sine_of(longint'((longint'(unsigned'(angle)) * t) >> 16));
         for (int i = 0; i < 4; i++) begin
            n = longint'(it.s[i]) * s1 + longint'(it.e[i]) * s2;
            mag = (n < 0) ? -n : n;
            q = (mag + s / 2) / s;
            if (n < 0) q = -q;
            if (q < -(longint'(1) << (W - 1))) q = -(longint'(1) << (W - 1));
            if (q > (longint'(1) << (W - 1)) - 1) q = (longint'(1) << (W - 1)) - 1;
            r.q[i] = q[W-1:0];
         end
      end
      return r;
   endfunction

   task automatic add_req(input int sw, sx, sy, sz, ew, ex, ey, ez,
                          input int unsigned bl, input bit drain = 0);
      slerp_req_type it;
      it.s[0] = W'(sw); it.s[1] = W'(sx); it.s[2] = W'(sy); it.s[3] = W'(sz);
      it.e[0] = W'(ew); it.e[1] = W'(ex); it.e[2] = W'(ey); it.e[3] = W'(ez);
      it.blend = qslerp_pkg::BLEND_W'(bl);
      it.drain = drain;
      pending_q.push_back(it);
   endtask

   // random unit quaternion in Q1.14, slightly off unit length at times
   task automatic unit_quat(output int q[4]);
      real a[4];
      real norm;
      real scale;
      norm = 0.0;
      for (int i = 0; i < 4; i++) begin
         a[i] = real'($urandom_range(20000)) - 10000.0;
         norm += a[i] * a[i];
      end
      if (norm < 1.0) begin
         a[0] = 1.0; norm = 1.0;
      end
      norm = $sqrt(norm);
      scale = 16384.0 * (0.97 + real'($urandom_range(60)) / 1000.0);
      for (int i = 0; i < 4; i++)
         q[i] = $rtoi(a[i] / norm * scale);
   endtask

   function automatic int unsigned rand_blend();
      case ($urandom_range(9))
         0: return 0;
         1: return qslerp_pkg::BLEND_ONE;
         2: return $urandom_range(131071, 65537);
         default: return $urandom_range(65536);
      endcase
   endfunction

   // stimulus
   initial begin
      int a[4];
      int b[4];
      int k;
      reset = 1'b1;

      // identical endpoints and opposite endpoints clamp to a zero sine
      add_req(16384, 0, 0, 0, 16384, 0, 0, 0, 32768);
      add_req(16384, 0, 0, 0, -16384, 0, 0, 0, 32768);
      add_req(0, 16384, 0, 0, 0, 16384, 0, 0, 0);
      // orthogonal endpoints across blend extremes and blend above one
      add_req(16384, 0, 0, 0, 0, 16384, 0, 0, 0);
      add_req(16384, 0, 0, 0, 0, 16384, 0, 0, 65536);
      add_req(16384, 0, 0, 0, 0, 0, 16384, 0, 131071);
      add_req(16384, 0, 0, 0, 0, 0, 0, 16384, 16384);
      add_req(0, 0, 16384, 0, 0, 0, 0, -16384, 49152);
      // obtuse, acute and right angles
      add_req(16384, 0, 0, 0, -11585, 11585, 0, 0, 32768);
      add_req(16384, 0, 0, 0, 11585, 11585, 0, 0, 32768);
      add_req(8192, 8192, 8192, 8192, 8192, -8192, 8192, -8192, 20000);
      // nearly equal and nearly opposite endpoints: tiny sine
      add_req(16384, 0, 0, 0, 16383, 1, 0, 0, 32768);
      add_req(16384, 0, 0, 0, -16383, 1, 0, 0, 1);
      // zeros and field extremes, dot clamps and outputs saturate
      add_req(0, 0, 0, 0, 0, 0, 0, 0, 32768);
      add_req(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 65536);
      add_req(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767, 100);
      add_req(-32768, 32767, -32768, 32767, -32768, -32768, 32767, 32767, 65535);
      add_req(32767, -32768, 0, 0, 0, 0, 32767, -32768, 32768);
      add_req(1, 0, 0, 0, 0, 1, 0, 0, 32768);
      add_req(-1, -1, -1, -1, 1, 1, 1, 1, 131071);

      for (int n = 0; n < N_RANDOM; n++) begin
         k = $urandom_range(99);
         unit_quat(a);
         if (k < 15) begin
            for (int i = 0; i < 4; i++)
               a[i] = $urandom_range(65535) - 32768;
            for (int i = 0; i < 4; i++)
               b[i] = $urandom_range(65535) - 32768;
            add_req(a[0], a[1], a[2], a[3], b[0], b[1], b[2], b[3],
                    $urandom_range(131071), n == 200);
            continue;
         end else if (k < 25) begin
            for (int i = 0; i < 4; i++)
               b[i] = (k < 20) ? a[i] : -a[i];
         end else if (k < 45) begin
            for (int i = 0; i < 4; i++)
               b[i] = a[i] + $urandom_range(64) - 32;
         end else begin
            unit_quat(b);
         end
         add_req(a[0], a[1], a[2], a[3], b[0], b[1], b[2], b[3], rand_blend(), n == 200);
      end

      repeat (11) @(negedge clock);
      reset = 1'b0;

      while (pending_q.size() != 0 || req_ch.valid || expected_q.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (n_errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #5000000;
      $display("simulation failed");
      $finish;
   end

   // idle pattern by progress
   always_comb begin
      if (n_accepted < 180) begin
         tx_idle = 21; rx_idle = 86;
      end else if (n_accepted < 360) begin
         tx_idle = 86; rx_idle = 21;
      end else begin
         tx_idle = 0; rx_idle = 0;
      end
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_took) begin
         if (pending_q.size() == 0 ||
             (pending_q[0].drain && expected_q.size() != 0) ||
             $urandom_range(99) < tx_idle) begin
            req_ch.valid <= 1'b0;
         end else begin
            slerp_req_type it;
            it = pending_q.pop_front();
            req_ch.start_w <= it.s[0];
            req_ch.start_x <= it.s[1];
            req_ch.start_y <= it.s[2];
            req_ch.start_z <= it.s[3];
            req_ch.end_w <= it.e[0];
            req_ch.end_x <= it.e[1];
            req_ch.end_y <= it.e[2];
            req_ch.end_z <= it.e[3];
            req_ch.blend <= it.blend;
            req_ch.valid <= 1'b1;
         end
      end
   end

   // response ready, with one long hold-off once the pipe runs at full rate
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt = hold_cnt - 1;
         rsp_ch.ready <= 1'b0;
      end else if (!hold_done && n_accepted >= 380) begin
         hold_done = 1'b1;
         hold_cnt = 300;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rx_idle);
      end
   end

   // transfer monitor and checker
   always @(posedge clock) begin
      req_took = req_ch.valid && req_ch.ready;
      if (!reset && req_took) begin
         slerp_req_type it;
         it.s[0] = req_ch.start_w; it.s[1] = req_ch.start_x;
         it.s[2] = req_ch.start_y; it.s[3] = req_ch.start_z;
         it.e[0] = req_ch.end_w; it.e[1] = req_ch.end_x;
         it.e[2] = req_ch.end_y; it.e[3] = req_ch.end_z;
         it.blend = req_ch.blend;
         it.drain = 0;
         expected_q.push_back(predict_slerp(it));
         n_accepted++;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_q.size() == 0) begin
            $display("%t unexpected result w=%0d x=%0d y=%0d z=%0d degenerate=%0b", $time,
                     rsp_ch.out_w, rsp_ch.out_x, rsp_ch.out_y, rsp_ch.out_z,
                     rsp_ch.degenerate);
            n_errors++;
         end else begin
            slerp_rsp_type ex;
            logic signed [W-1:0] got[4];
            ex = expected_q.pop_front();
            got[0] = rsp_ch.out_w; got[1] = rsp_ch.out_x;
            got[2] = rsp_ch.out_y; got[3] = rsp_ch.out_z;
            for (int i = 0; i < 4; i++) begin
               if (got[i] !== ex.q[i]) begin
                  $display("%t component %0d expected %0d actual %0d", $time, i,
                           ex.q[i], got[i]);
                  n_errors++;
               end
            end
            if (rsp_ch.degenerate !== ex.degenerate) begin
               $display("%t degenerate expected %0b actual %0b", $time,
                        ex.degenerate, rsp_ch.degenerate);
               n_errors++;
            end
         end
      end
   end

endmodule
